@@ rtl/cle_pkg.sv @@
// circular list engine package: request and status codes, allocator command
// no dependencies
`timescale 1ns / 1ps

package cle_pkg;

   localparam int DATA_W = 32;
   localparam int COUNT_W = 5;

   // request codes
   localparam logic [2:0] REQ_APPEND     = 3'd0;
   localparam logic [2:0] REQ_PREPEND    = 3'd1;
   localparam logic [2:0] REQ_INS_FIRST  = 3'd2;
   localparam logic [2:0] REQ_INS_ALL    = 3'd3;
   localparam logic [2:0] REQ_DEL_FIRST  = 3'd4;
   localparam logic [2:0] REQ_DEL_ALL    = 3'd5;
   localparam logic [2:0] REQ_SEARCH     = 3'd6;
   localparam logic [2:0] REQ_DUMP       = 3'd7;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // slot allocator command
   typedef struct packed {
      logic take;
      logic give;
   } alloc_cmd_type;

endpackage

@@ rtl/cle_req_if.sv @@
// request channel interface: valid/ready plus request payload
// depends on cle_pkg
`timescale 1ns / 1ps

interface cle_req_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          req_type;
   logic signed [cle_pkg::DATA_W-1:0]   match_key;
   logic signed [cle_pkg::DATA_W-1:0]   new_value;

   modport source (output valid, output req_type, output match_key, output new_value,
                   input ready);
   modport sink (input valid, input req_type, input match_key, input new_value,
                 output ready);
endinterface

@@ rtl/cle_rsp_if.sv @@
// response channel interface: valid/ready plus result payload
// depends on cle_pkg
`timescale 1ns / 1ps

interface cle_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [cle_pkg::COUNT_W-1:0]         match_count;
   logic signed [cle_pkg::DATA_W-1:0]   element;
   logic                                last;

   modport source (output valid, output status, output match_count, output element,
                   output last, input ready);
   modport sink (input valid, input status, input match_count, input element,
                 input last, output ready);
endinterface

@@ rtl/circular_list_engine_top.sv @@
// circular list engine top: request sequencer, value and link memories
// depends on cle_pkg, cle_req_if, cle_rsp_if, cle_free_alloc
`timescale 1ns / 1ps

// Keeps a ring of up to CAPACITY signed 32-bit values in a value memory and a
// link memory, and serves one request at a time; req_chan.ready is low while a
// request is in progress. Every non-empty request first scans the ring with one
// shared key comparator, each entry taking a memory read and then a compare, to
// count matches and find the tail. Search answers after that scan. Keyed inserts
// and deletes then make a second read-then-compare pass, with an extra link write
// for each inserted node; append and prepend then, unless the ring is full, write
// the new node and the tail link. A dump streams one result per entry (read,
// compare, transfer) and waits on rsp_chan.ready for each. On an empty ring,
// keyed requests and dumps answer EMPTY straight from idle, and append and
// prepend answer after writing the new node.

module circular_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   cle_req_if.sink    req_chan,
   cle_rsp_if.source  rsp_chan
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = cle_pkg::DATA_W;

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_EX1, S_DOUT, S_DECIDE, S_RD2, S_EX2, S_LINK2,
      S_APP1, S_APP2, S_RESP
   } state_type;

   state_type         state_ff;
   logic [2:0]        op_ff;
   logic [DW-1:0]     key_ff;
   logic [DW-1:0]     val_ff;
   logic [IW-1:0]     head_ff;
   logic [CW-1:0]     count_ff;
   logic [IW-1:0]     cur_ff;
   logic [IW-1:0]     next_ff;
   logic [IW-1:0]     prev_ff;
   logic [IW-1:0]     tail_ff;
   logic [IW-1:0]     pend_ff;
   logic [IW-1:0]     newhead_ff;
   logic              kept_ff;
   logic [CW-1:0]     walk_ff;
   logic [CW-1:0]     hits_ff;
   logic [CW-1:0]     done_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [cle_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [DW-1:0]     rsp_elem_ff;
   logic              rsp_last_ff;

   // memories with registered read
   logic [DW-1:0]     value_mem [CAPACITY];
   logic [IW-1:0]     link_mem [CAPACITY];
   logic [DW-1:0]     rd_val_ff;
   logic [IW-1:0]     rd_link_ff;

   logic              val_we;
   logic [IW-1:0]     val_wa;
   logic              link_we;
   logic [IW-1:0]     link_wa;
   logic [IW-1:0]     link_wd;

   cle_pkg::alloc_cmd_type alloc_cmd;
   logic [IW-1:0]     alloc_idx;

   logic              req_xfer;
   logic              rsp_xfer;
   logic              key_hit;
   logic              is_insert;
   logic              is_first;
   logic [CW-1:0]     limit;
   logic              pass2_hit;
   logic [CW:0]       want;
   logic              last_step;

   cle_free_alloc #(
      .CAPACITY (CAPACITY),
      .IW       (IW)
   ) u_alloc (
      .clock     (clock),
      .reset     (reset),
      .cmd       (alloc_cmd),
      .give_idx  (cur_ff),
      .alloc_idx (alloc_idx)
   );

   // handshakes and payload
   assign req_chan.ready       = (state_ff == S_IDLE);
   assign req_xfer             = req_chan.valid && req_chan.ready;
   assign rsp_xfer             = rsp_valid_ff && rsp_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.match_count = rsp_count_ff;
   assign rsp_chan.element     = rsp_elem_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // shared key comparator and pass-two qualifiers
   assign key_hit   = (rd_val_ff == key_ff);
   assign is_insert = (op_ff == cle_pkg::REQ_INS_FIRST) || (op_ff == cle_pkg::REQ_INS_ALL);
   assign is_first  = (op_ff == cle_pkg::REQ_INS_FIRST) || (op_ff == cle_pkg::REQ_DEL_FIRST);
   assign limit     = is_first ? CW'(1) : hits_ff;
   assign pass2_hit = key_hit && (done_ff < limit);
   assign want      = is_first ? (CW+1)'(1) : {1'b0, hits_ff};
   assign last_step = (walk_ff == CW'(1));

   // memory write and allocator control
   always_comb begin
      val_we    = 1'b0;
      val_wa    = alloc_idx;
      link_we   = 1'b0;
      link_wa   = alloc_idx;
      link_wd   = rd_link_ff;
      alloc_cmd = '0;
      case (state_ff)
         S_EX2: begin
            if (pass2_hit && is_insert) begin
               val_we         = 1'b1;
               link_we        = 1'b1;
               alloc_cmd.take = 1'b1;
            end else if (pass2_hit) begin
               link_we        = 1'b1;
               link_wa        = prev_ff;
               alloc_cmd.give = 1'b1;
            end
         end
         S_LINK2: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = pend_ff;
         end
         S_APP1: begin
            val_we         = 1'b1;
            link_we        = 1'b1;
            link_wd        = (count_ff == '0) ? alloc_idx : head_ff;
            alloc_cmd.take = 1'b1;
         end
         S_APP2: begin
            link_we = 1'b1;
            link_wa = tail_ff;
            link_wd = pend_ff;
         end
         default: begin
         end
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[val_wa] <= val_ff;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      rd_val_ff  <= value_mem[cur_ff];
      rd_link_ff <= link_mem[cur_ff];
   end

   // request sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  op_ff   <= req_chan.req_type;
                  key_ff  <= req_chan.match_key;
                  val_ff  <= req_chan.new_value;
                  cur_ff  <= head_ff;
                  tail_ff <= head_ff;
                  walk_ff <= count_ff;
                  hits_ff <= '0;
                  if (count_ff != '0) begin
                     state_ff <= S_RD1;
                  end else if (req_chan.req_type == cle_pkg::REQ_APPEND ||
                               req_chan.req_type == cle_pkg::REQ_PREPEND) begin
                     state_ff <= S_APP1;
                  end else begin
                     rsp_status_ff <= cle_pkg::ST_EMPTY;
                     rsp_count_ff  <= '0;
                     rsp_elem_ff   <= '0;
                     rsp_last_ff   <= 1'b1;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_RESP;
                  end
               end
            end
            S_RD1: begin
               state_ff <= S_EX1;
            end
            // scan pass: count matches, find tail, stream dump
            S_EX1: begin
               hits_ff <= hits_ff + CW'(key_hit);
               tail_ff <= cur_ff;
               cur_ff  <= rd_link_ff;
               walk_ff <= walk_ff - CW'(1);
               if (op_ff == cle_pkg::REQ_DUMP) begin
                  rsp_status_ff <= cle_pkg::ST_OK;
                  rsp_count_ff  <= '0;
                  rsp_elem_ff   <= rd_val_ff;
                  rsp_last_ff   <= last_step;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_DOUT;
               end else if (last_step) begin
                  state_ff <= S_DECIDE;
               end else begin
                  state_ff <= S_RD1;
               end
            end
            S_DOUT: begin
               if (rsp_xfer) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= rsp_last_ff ? S_IDLE : S_RD1;
               end
            end
            S_DECIDE: begin
               cur_ff      <= head_ff;
               walk_ff     <= count_ff;
               done_ff     <= '0;
               prev_ff     <= tail_ff;
               kept_ff     <= 1'b0;
               newhead_ff  <= '0;
               rsp_elem_ff <= '0;
               rsp_last_ff <= 1'b1;
               rsp_count_ff <= '0;
               if (op_ff == cle_pkg::REQ_APPEND || op_ff == cle_pkg::REQ_PREPEND) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rsp_status_ff <= cle_pkg::ST_FULL;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_APP1;
                  end
               end else if (hits_ff == '0) begin
                  rsp_status_ff <= cle_pkg::ST_NOT_FOUND;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else if (op_ff == cle_pkg::REQ_SEARCH) begin
                  rsp_status_ff <= cle_pkg::ST_OK;
                  rsp_count_ff  <= cle_pkg::COUNT_W'(hits_ff);
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else if (is_insert && ({1'b0, count_ff} + want > (CW+1)'(CAPACITY))) begin
                  rsp_status_ff <= cle_pkg::ST_FULL;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else begin
                  state_ff <= S_RD2;
               end
            end
            S_RD2: begin
               state_ff <= S_EX2;
            end
            // modify pass over original nodes
            S_EX2: begin
               next_ff <= rd_link_ff;
               if (pass2_hit && is_insert) begin
                  done_ff  <= done_ff + CW'(1);
                  pend_ff  <= alloc_idx;
                  state_ff <= S_LINK2;
               end else begin
                  if (pass2_hit) begin
                     done_ff <= done_ff + CW'(1);
                  end else if (!is_insert) begin
                     prev_ff <= cur_ff;
                     if (!kept_ff) begin
                        kept_ff    <= 1'b1;
                        newhead_ff <= cur_ff;
                     end
                  end
                  cur_ff  <= rd_link_ff;
                  walk_ff <= walk_ff - CW'(1);
                  state_ff <= last_step ? S_RESP : S_RD2;
                  if (last_step) begin
                     rsp_status_ff <= cle_pkg::ST_OK;
                     rsp_valid_ff  <= 1'b1;
                     if (is_insert) begin
                        rsp_count_ff <= cle_pkg::COUNT_W'(done_ff);
                        count_ff     <= count_ff + done_ff;
                     end else begin
                        rsp_count_ff <= cle_pkg::COUNT_W'(done_ff + CW'(pass2_hit));
                        count_ff     <= count_ff - done_ff - CW'(pass2_hit);
                        if (kept_ff) begin
                           head_ff <= newhead_ff;
                        end else if (!pass2_hit) begin
                           head_ff <= cur_ff;
                        end else begin
                           head_ff <= '0;
                        end
                     end
                  end
               end
            end
            S_LINK2: begin
               cur_ff   <= next_ff;
               walk_ff  <= walk_ff - CW'(1);
               state_ff <= last_step ? S_RESP : S_RD2;
               if (last_step) begin
                  rsp_status_ff <= cle_pkg::ST_OK;
                  rsp_count_ff  <= cle_pkg::COUNT_W'(done_ff);
                  rsp_valid_ff  <= 1'b1;
                  count_ff      <= count_ff + done_ff;
               end
            end
            // append or prepend: new node, then tail link on a non-empty ring
            S_APP1: begin
               pend_ff       <= alloc_idx;
               rsp_status_ff <= cle_pkg::ST_OK;
               rsp_count_ff  <= cle_pkg::COUNT_W'(1);
               rsp_elem_ff   <= '0;
               rsp_last_ff   <= 1'b1;
               if (count_ff == '0) begin
                  head_ff      <= alloc_idx;
                  count_ff     <= CW'(1);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else begin
                  state_ff <= S_APP2;
               end
            end
            S_APP2: begin
               if (op_ff == cle_pkg::REQ_PREPEND) begin
                  head_ff <= pend_ff;
               end
               count_ff     <= count_ff + CW'(1);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (rsp_xfer) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // stored entries never exceed the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count above capacity");

   // no new request while a result is pending
   a_ready_vs_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_valid_ff)) else $error("ready with result pending");

   // a walk step always has an entry left to visit
   a_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EX1 || state_ff == S_EX2) |-> walk_ff != '0)
      else $error("walk past ring end");

   // an empty ring keeps its head at slot zero
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff == '0) |-> head_ff == '0)
      else $error("empty ring with nonzero head");

endmodule

@@ rtl/cle_free_alloc.sv @@
// free slot map with lowest-free-slot allocator
// depends on cle_pkg
`timescale 1ns / 1ps

module cle_free_alloc #(
   parameter int CAPACITY = 16,
   parameter int IW = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cle_pkg::alloc_cmd_type cmd,
   input  logic [IW-1:0]          give_idx,
   output logic [IW-1:0]          alloc_idx
);

   logic [CAPACITY-1:0] free_ff;
   logic [CAPACITY-1:0] free_in;

   // priority search for the lowest free slot
   always_comb begin
      alloc_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            alloc_idx = IW'(i);
         end
      end
   end

   // map update
   always_comb begin
      free_in = free_ff;
      if (cmd.take) begin
         free_in[alloc_idx] = 1'b0;
      end
      if (cmd.give) begin
         free_in[give_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else begin
         free_ff <= free_in;
      end
   end

   // never allocate from an exhausted map
   a_take_has_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> free_ff != '0) else $error("allocation with no free slot");

   // a slot is released only while in use
   a_no_double_free: assert property (@(posedge clock) disable iff (reset)
      cmd.give |-> !free_ff[give_idx]) else $error("slot released twice");

   // take and give never coincide
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take && cmd.give)) else $error("take and give in one cycle");

endmodule
